FILE: src/fzoa_pkg.sv
// ----------------------------------------------------------------------------
// fzoa_pkg
// Shared types and constants for the fuzzy obstacle avoidance controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fzoa_pkg;

	localparam int SensorW = 10;
	localparam int MemW    = 11;            // membership 0..1024 in Q10
	localparam int SpeedW  = 12;
	localparam int MemFrac = 10;
	localparam int SpdFrac = 8;

	localparam logic [MemW-1:0] MemOne = MemW'(1 << MemFrac);

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_FAR_FLAT_END    = 2'd0;
	localparam logic [1:0] REG_FAR_END         = 2'd1;
	localparam logic [1:0] REG_NEAR_START      = 2'd2;
	localparam logic [1:0] REG_NEAR_FLAT_START = 2'd3;

	typedef enum logic [1:0] {
		MEM_ZERO,
		MEM_FRAC,
		MEM_ONE
	} mem_kind_t;

	typedef struct packed {
		logic [SensorW-1:0] far_flat_end;
		logic [SensorW-1:0] far_end;
		logic [SensorW-1:0] near_start;
		logic [SensorW-1:0] near_flat_start;
	} cfg_t;

	typedef struct packed {
		mem_kind_t          kind;
		logic [SensorW-1:0] num;
		logic [SensorW-1:0] den;
	} mem_class_t;

endpackage

`default_nettype wire

FILE: src/fzoa_div.sv
// ----------------------------------------------------------------------------
// fzoa_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module fzoa_div #(
	parameter int NW = 21,
	parameter int DW = 10,
	parameter int QB = 11,
	parameter int SW = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side,
	output logic               out_valid,
	output logic [QB-1:0]      quo,
	output logic [SW-1:0]      side_out
);

	localparam int TW = (NW > DW + QB) ? NW : DW + QB;

	logic          vld_s  [QB+1];
	logic [NW-1:0] rem_s  [QB+1];
	logic [DW-1:0] den_s  [QB+1];
	logic [QB-1:0] quo_s  [QB+1];
	logic [SW-1:0] side_s [QB+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side;

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [TW-1:0] trial;
		logic          take;

		// Stage k decides quotient bit QB-1-k.
		always_comb begin
			trial = TW'(den_s[k]) << (QB - 1 - k);
			take  = TW'(rem_s[k]) >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? rem_s[k] - trial[NW-1:0] : rem_s[k];
				den_s[k+1]  <= den_s[k];
				quo_s[k+1]  <= {quo_s[k][QB-2:0], take};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[QB];
	assign quo       = quo_s[QB];
	assign side_out  = side_s[QB];

endmodule

`default_nettype wire

FILE: src/fzoa_fuzzify.sv
// ----------------------------------------------------------------------------
// fzoa_fuzzify
// Side maxima, trapezoid memberships and the rule base.
// ----------------------------------------------------------------------------
`default_nettype none

module fzoa_fuzzify
	import fzoa_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire logic [5:0][SensorW-1:0]  sensors,
	input  wire cfg_t                     cfg,
	output logic                          out_valid,
	output logic [MemW-1:0]               dec_l,
	output logic [MemW-1:0]               inc_l,
	output logic [MemW-1:0]               inc_r
);

	logic               vld_s1, vld_s2, vld_s3;
	logic [SensorW-1:0] left_s1, right_s1;
	mem_class_t         cls_s2 [4];     // far left, near left, far right, near right
	mem_class_t         cls_c  [4];
	logic [SensorW-1:0] lmax, rmax;
	logic [3:0]         dvld;
	logic [MemW-1:0]    dquo [4];
	logic [1:0]         dkind [4];
	logic [MemW-1:0]    mem [4];
	logic [MemW-1:0]    dec_s3, incl_s3, incr_s3;

	function automatic logic [SensorW-1:0] max3(input logic [SensorW-1:0] a,
			input logic [SensorW-1:0] b, input logic [SensorW-1:0] c);
		logic [SensorW-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic mem_class_t far_class(input logic [SensorW-1:0] v, input cfg_t c);
		mem_class_t r;
		r = '{kind: MEM_ONE, num: '0, den: SensorW'(1)};
		if (v > c.far_end) begin
			r.kind = MEM_ZERO;
		end else if (v > c.far_flat_end) begin
			r.kind = MEM_FRAC;
			r.num  = c.far_end - v;
			r.den  = c.far_end - c.far_flat_end;
		end
		return r;
	endfunction

	function automatic mem_class_t near_class(input logic [SensorW-1:0] v, input cfg_t c);
		mem_class_t r;
		r = '{kind: MEM_ONE, num: '0, den: SensorW'(1)};
		if (v < c.near_start) begin
			r.kind = MEM_ZERO;
		end else if (v < c.near_flat_start) begin
			r.kind = MEM_FRAC;
			r.num  = v - c.near_start;
			r.den  = c.near_flat_start - c.near_start;
		end
		return r;
	endfunction

	function automatic logic [MemW-1:0] mmin(input logic [MemW-1:0] a, input logic [MemW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [MemW-1:0] mmax(input logic [MemW-1:0] a, input logic [MemW-1:0] b);
		return (a < b) ? b : a;
	endfunction

	always_comb begin
		lmax     = max3(sensors[0], sensors[1], sensors[2]);
		rmax     = max3(sensors[3], sensors[4], sensors[5]);
		cls_c[0] = far_class(left_s1, cfg);
		cls_c[1] = near_class(left_s1, cfg);
		cls_c[2] = far_class(right_s1, cfg);
		cls_c[3] = near_class(right_s1, cfg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			left_s1  <= lmax;
			right_s1 <= rmax;
			for (int i = 0; i < 4; i++) begin
				cls_s2[i] <= cls_c[i];
			end
		end
	end

	// The rounded ratio is taken as half of a quotient with one extra bit.
	for (genvar i = 0; i < 4; i++) begin : g_mem
		fzoa_div #(
			.NW(SensorW + MemFrac + 1),
			.DW(SensorW),
			.QB(MemFrac + 1),
			.SW(2)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld_s2),
			.num       ({cls_s2[i].num, (MemFrac + 1)'(0)}),
			.den       (cls_s2[i].den),
			.side      (cls_s2[i].kind),
			.out_valid (dvld[i]),
			.quo       (dquo[i]),
			.side_out  (dkind[i])
		);

		logic [MemW:0] rounded;

		always_comb begin
			rounded = ({1'b0, dquo[i]} + (MemW + 1)'(1)) >> 1;
			case (mem_kind_t'(dkind[i]))
				MEM_ZERO: mem[i] = '0;
				MEM_FRAC: mem[i] = rounded[MemW-1:0];
				MEM_ONE:  mem[i] = MemOne;
				default:  mem[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= &dvld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			incl_s3 <= mmin(mem[0], mem[2]);
			dec_s3  <= mmax(mmin(mem[3], mem[0]), mmin(mem[1], mem[3]));
			incr_s3 <= mmax(mmin(mem[1], mem[2]), mmin(mem[0], mem[2]));
		end
	end

	assign out_valid = vld_s3;
	assign dec_l     = dec_s3;
	assign inc_l     = incl_s3;
	assign inc_r     = incr_s3;

endmodule

`default_nettype wire

FILE: src/fzoa_defuzz.sv
// ----------------------------------------------------------------------------
// fzoa_defuzz
// Centroid of two clipped output trapezoids for one motor, rounded to Q8.
// ----------------------------------------------------------------------------
`default_nettype none

module fzoa_defuzz
	import fzoa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [MemW-1:0]    hd,
	input  wire logic [MemW-1:0]    hi,
	output logic                    out_valid,
	output logic signed [SpeedW-1:0] speed
);

	localparam int AreaW = 2 * MemW + 1;        // h*(5-h) in Q20
	localparam int SumW  = AreaW + 1;
	localparam int WtW   = MemW + 4;            // 5 + 2h in Q10
	localparam int ProdW = AreaW + WtW;
	localparam int MagW  = SumW + MemFrac + 1;  // also width of the divisor
	localparam int QB    = SpdFrac + 4;
	localparam logic [WtW-1:0] Five = WtW'(5 << MemFrac);

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic [AreaW-1:0]   ad_s1, ai_s1;
	logic [MemW-1:0]    hd_s1, hi_s1;
	logic [ProdW-1:0]   pos_s2, neg_s2;
	logic [SumW-1:0]    sum_s2;
	logic [MagW-1:0]    mag_s3, den_s3;
	logic               neg_s3, zero_s3;
	logic               dvld;
	logic [QB-1:0]      dquo;
	logic [1:0]         dside;
	logic [QB:0]        rnd;
	logic [SpeedW-1:0]  mag_r;
	logic [SpeedW-1:0]  spd_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= dvld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ad_s1  <= AreaW'(hd * (Five - WtW'(hd)));
			ai_s1  <= AreaW'(hi * (Five - WtW'(hi)));
			hd_s1  <= hd;
			hi_s1  <= hi;
			pos_s2 <= ProdW'(ai_s1 * (Five + (WtW'(hi_s1) << 1)));
			neg_s2 <= ProdW'(ad_s1 * (Five + (WtW'(hd_s1) << 1)));
			sum_s2 <= SumW'(ad_s1) + SumW'(ai_s1);
			neg_s3 <= neg_s2 > pos_s2;
			mag_s3 <= (neg_s2 > pos_s2) ? MagW'(neg_s2 - pos_s2) : MagW'(pos_s2 - neg_s2);
			den_s3 <= MagW'(sum_s2) << (MemFrac + 1);
			zero_s3 <= sum_s2 == '0;
		end
	end

	// Quotient carries one bit beyond Q8 for rounding.
	fzoa_div #(
		.NW(MagW + SpdFrac + 1),
		.DW(MagW),
		.QB(QB),
		.SW(2)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.num       ({mag_s3, (SpdFrac + 1)'(0)}),
		.den       (den_s3),
		.side      ({neg_s3, zero_s3}),
		.out_valid (dvld),
		.quo       (dquo),
		.side_out  (dside)
	);

	always_comb begin
		rnd   = ({1'b0, dquo} + (QB + 1)'(1)) >> 1;
		mag_r = rnd[SpeedW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dside[0]) begin
				spd_s4 <= '0;
			end else if (dside[1]) begin
				spd_s4 <= SpeedW'(0) - mag_r;
			end else begin
				spd_s4 <= mag_r;
			end
		end
	end

	assign out_valid = vld_s4;
	assign speed     = signed'(spd_s4);

endmodule

`default_nettype wire

FILE: src/fuzzy_obstacle_avoid_controller.sv
// ----------------------------------------------------------------------------
// fuzzy_obstacle_avoid_controller
// Two-input fuzzy controller turning six proximity readings into motor speeds.
// ----------------------------------------------------------------------------
// The slave channel takes one beat of six 10-bit readings; the master channel
// returns one beat with the left and right speeds in signed Q8.
// The configuration port writes the four trapezoid breakpoints; it must be
// used only while no beat is in flight; the block itself does not enforce it.
// From an accepted input beat to its output beat the pipeline runs through two
// setup stages, an 11-stage membership divider, one rule stage, three area
// stages, a 12-stage centroid divider and a rounding stage. Throughput is one
// beat per clock while the output is not stalled; every stage is a register.
// The whole pipeline advances together; when the receiver holds tready low
// with a beat waiting, the pipeline freezes and s_tready drops, so nothing
// is lost or repeated. Empty pipelines and idle outputs never block input.
// Reset clears all valid bits and loads breakpoints 400, 500, 500 and 600.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_obstacle_avoid_controller
	import fzoa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // sensor_0 .. sensor_5, 10 bits each
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // left_speed, right_speed, 12 bits each
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [9:0]  cfg_data
);

	cfg_t                     cfg_q;
	logic                     en;
	logic [5:0][SensorW-1:0]  sensors;
	logic                     fz_valid;
	logic [MemW-1:0]          dec_l, inc_l, inc_r;
	logic                     lv, rv;
	logic signed [SpeedW-1:0] left_speed, right_speed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.far_flat_end    <= SensorW'(400);
			cfg_q.far_end         <= SensorW'(500);
			cfg_q.near_start      <= SensorW'(500);
			cfg_q.near_flat_start <= SensorW'(600);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FAR_FLAT_END:    cfg_q.far_flat_end    <= cfg_data;
				REG_FAR_END:         cfg_q.far_end         <= cfg_data;
				REG_NEAR_START:      cfg_q.near_start      <= cfg_data;
				REG_NEAR_FLAT_START: cfg_q.near_flat_start <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign sensors  = s_tdata[6*SensorW-1:0];

	fzoa_fuzzify u_fuzzify (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.sensors   (sensors),
		.cfg       (cfg_q),
		.out_valid (fz_valid),
		.dec_l     (dec_l),
		.inc_l     (inc_l),
		.inc_r     (inc_r)
	);

	fzoa_defuzz u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fz_valid),
		.hd        (dec_l),
		.hi        (inc_l),
		.out_valid (lv),
		.speed     (left_speed)
	);

	// The right motor has no decrease rule.
	fzoa_defuzz u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fz_valid),
		.hd        ('0),
		.hi        (inc_r),
		.out_valid (rv),
		.speed     (right_speed)
	);

	assign m_tvalid = lv && rv;
	assign m_tdata  = {right_speed, left_speed};

endmodule

`default_nettype wire

FILE: src/fzoa_checker.sv
// ----------------------------------------------------------------------------
// fzoa_checker
// Port-level checks for the fuzzy obstacle avoidance controller.
// ----------------------------------------------------------------------------
`default_nettype none

module fzoa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);

	// A waiting result must stay offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output beat changed while stalled");

	// The input side is held back only by a stalled output beat.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// The right motor only ever speeds up, and the left stays within five.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[23] && ($signed(m_tdata[11:0]) >= -12'sd1280)
			&& ($signed(m_tdata[11:0]) <= 12'sd1280))
		else $error("speed out of range");

endmodule

bind fuzzy_obstacle_avoid_controller fzoa_checker u_fzoa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
